FILE: hw/rtl/rgbw_pkg.sv
`default_nettype none

package rgbw_pkg;

  localparam int unsigned WIN_SIDE    = 3;
  localparam int unsigned WIN_CELLS   = WIN_SIDE * WIN_SIDE;
  localparam int unsigned CENTRE_ROW  = WIN_SIDE / 2;
  localparam int unsigned CENTRE_CELL = CENTRE_ROW * WIN_SIDE + WIN_SIDE / 2;
  localparam int unsigned NUM_CH      = 3;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned ROW_W    = 10;
  localparam int unsigned SUM_W    = 12;
  localparam int unsigned RECIP_W  = 13;
  localparam int unsigned PROD_W   = SUM_W + RECIP_W;
  localparam int unsigned RECIP_SH = 16;

  // floor(x / 9) == (x * 7282) >> 16 for every x below 2^12
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;

  localparam logic [IDX_W-1:0] FULL_LEN = IDX_W'(WIN_CELLS);
  localparam logic [IDX_W-1:0] COL_LEN  = IDX_W'(WIN_SIDE);
  localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(WIN_SIDE - 1);

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [CH_W-1:0] pix_red;
    logic [CH_W-1:0] pix_green;
    logic [CH_W-1:0] pix_blue;
    logic            full_reload;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } out_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pix_t;

  typedef pix_t [WIN_CELLS-1:0] win_t;

  function automatic logic [CH_W-1:0] pix_chan(pix_t p, logic [1:0] ch);
    logic [CH_W-1:0] v;
    case (ch)
      CH_RED:   v = p.red;
      CH_GREEN: v = p.green;
      CH_BLUE:  v = p.blue;
      default:  v = p.blue;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rgbw_window.sv
`default_nettype none

module rgbw_window
  import rgbw_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  input  wire logic take_i,
  output logic      fire_o,
  output win_t      win_o
);

  win_t win_q, win_d;
  idx_t idx_q, idx_d;
  logic full_q, full_d;
  logic fire_q, fire_d;

  logic accept;
  logic full_eff;
  logic complete;
  idx_t idx_eff;
  idx_t grp_len;
  idx_t pos;
  idx_t idx_nxt;
  pix_t pix;

  assign in_ready_o = !fire_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pix = {in_data_i.pix_blue, in_data_i.pix_green, in_data_i.pix_red};

  always_comb begin
    full_eff = (idx_q == '0) ? in_data_i.full_reload : full_q;
    grp_len  = full_eff ? FULL_LEN : COL_LEN;
    idx_eff  = (idx_q >= grp_len) ? '0 : idx_q;
    pos      = full_eff ? idx_eff : IDX_W'(idx_eff * COL_LEN + LAST_COL);
    idx_nxt  = idx_eff + 1'b1;
    complete = (idx_nxt >= grp_len);

    win_d = win_q;
    if (idx_q == '0 && !in_data_i.full_reload) begin
      // slide left, drop the leftmost column
      for (int r = 0; r < WIN_SIDE; r++) begin
        for (int c = 0; c + 1 < WIN_SIDE; c++) begin
          win_d[r * WIN_SIDE + c] = win_q[r * WIN_SIDE + c + 1];
        end
      end
    end
    if (pos < FULL_LEN) begin
      win_d[pos] = pix;
    end

    idx_d  = complete ? '0 : idx_nxt;
    full_d = full_eff;
    fire_d = (fire_q && !take_i) || (accept && complete);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      idx_q  <= '0;
      full_q <= 1'b0;
      fire_q <= 1'b0;
    end else begin
      fire_q <= fire_d;
      if (accept) begin
        win_q  <= win_d;
        idx_q  <= idx_d;
        full_q <= full_d;
      end
    end
  end

  assign fire_o = fire_q;
  assign win_o  = win_q;

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < FULL_LEN) else $error("group position out of range");

  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!full_q && idx_q != '0) |-> idx_q < COL_LEN)
    else $error("column group position out of range");

  a_fire_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_q |-> idx_q == '0) else $error("pending window while a group is open");

  a_fire_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && complete) |=> fire_q) else $error("completed group not flagged");

endmodule

`default_nettype wire

FILE: hw/rtl/rgbw_filter.sv
`default_nettype none

module rgbw_filter
  import rgbw_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic fire_i,
  output logic      take_o,
  input  wire win_t win_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic [ROW_W-1:0] rs_d [NUM_CH][WIN_SIDE];
  logic [ROW_W-1:0] rs_q [NUM_CH][WIN_SIDE];
  logic [CH_W-1:0]  rm_d [NUM_CH][WIN_SIDE];
  logic [CH_W-1:0]  rm_q [NUM_CH][WIN_SIDE];
  logic [SUM_W-1:0] diff_d [NUM_CH];
  logic [SUM_W-1:0] diff_q [NUM_CH];
  logic [CH_W-1:0]  res_d [NUM_CH];
  logic [CH_W-1:0]  res_q [NUM_CH];

  assign rdy3   = !v3_q || out_ready_i;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign take_o = rdy1;

  // row sums and row maxima, centre counted twice
  always_comb begin
    logic [CH_W-1:0] v;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int r = 0; r < WIN_SIDE; r++) begin
        rs_d[ch][r] = '0;
        rm_d[ch][r] = '0;
        for (int c = 0; c < WIN_SIDE; c++) begin
          v = pix_chan(win_i[r * WIN_SIDE + c], 2'(ch));
          rs_d[ch][r] = rs_d[ch][r] + ROW_W'(v);
          if (r * WIN_SIDE + c == CENTRE_CELL) begin
            rs_d[ch][r] = rs_d[ch][r] + ROW_W'(v);
          end
          if (v > rm_d[ch][r]) begin
            rm_d[ch][r] = v;
          end
        end
      end
    end
  end

  // total minus maximum
  always_comb begin
    logic [SUM_W-1:0] sum;
    logic [CH_W-1:0]  top;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum = SUM_W'(rs_q[ch][0]) + SUM_W'(rs_q[ch][1]) + SUM_W'(rs_q[ch][2]);
      top = rm_q[ch][0];
      if (rm_q[ch][1] > top) top = rm_q[ch][1];
      if (rm_q[ch][2] > top) top = rm_q[ch][2];
      diff_d[ch] = sum - SUM_W'(top);
    end
  end

  // divide by nine through the reciprocal
  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod       = PROD_W'(diff_q[ch]) * PROD_W'(DIV9_RECIP);
      res_d[ch]  = prod[RECIP_SH +: CH_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= fire_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && fire_i) begin
      rs_q <= rs_d;
      rm_q <= rm_d;
    end
    if (rdy2 && v1_q) begin
      diff_q <= diff_d;
    end
    if (rdy3 && v2_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = {res_q[CH_RED], res_q[CH_GREEN], res_q[CH_BLUE]};

  a_no_drop1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |=> v1_q) else $error("stage one lost an item");

  a_no_drop2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !rdy3) |=> v2_q) else $error("stage two lost an item");

  a_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && take_o) |=> v1_q) else $error("taken window not in stage one");

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_window_weighted_mean_drop_max.sv
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+-----------------------------------
// input    | in_valid_i  | in_ready_o  | in_data_i  (pixel, full_reload)
// output   | out_valid_o | out_ready_i | out_data_o (red, green, blue)
//
// One pixel per cycle is accepted while in_ready_o is high. The result of
// a completed group passes through the window register, row sum/max stage,
// subtract stage and reciprocal multiply into the output register.
// Reset clears the window to zeros and opens a new group.
// A result waiting at the output fills the three filter stages; once they
// and a completed window are all held, the input stalls for every pixel.
`default_nettype none

module rgb_window_weighted_mean_drop_max
  import rgbw_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic win_fire;
  logic win_take;
  win_t win;

  rgbw_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (win_take),
    .fire_o     (win_fire),
    .win_o      (win)
  );

  rgbw_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (win_fire),
    .take_o      (win_take),
    .win_i       (win),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: dv/rgb_window_weighted_mean_drop_max_test.sv
`default_nettype none

module rgb_window_weighted_mean_drop_max_test;
  import rgbw_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned HOLD_LEN    = 120;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  rgb_window_weighted_mean_drop_max i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [CH_W-1:0] win_ch [NUM_CH][WIN_CELLS] = '{default: '0};
  idx_t            pixel_pos  = '0;
  logic            group_full = 1'b0;
  out_t            filtered_q [$];

  bit          gaps_on     = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned error_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned full_groups = 0;
  int unsigned col_groups  = 0;
  int unsigned windows_checked = 0;
  out_t        want;

  function automatic logic [CH_W-1:0] filter_channel(logic [1:0] ch);
    logic [SUM_W-1:0] sum;
    logic [CH_W-1:0]  peak;
    sum  = '0;
    peak = '0;
    for (int k = 0; k < WIN_CELLS; k++) begin
      sum = sum + SUM_W'(win_ch[ch][k]);
      if (k == CENTRE_CELL) sum = sum + SUM_W'(win_ch[ch][k]);
      if (win_ch[ch][k] > peak) peak = win_ch[ch][k];
    end
    return CH_W'((sum - SUM_W'(peak)) / 9);
  endfunction

  function automatic void absorb_pixel(in_t px);
    logic [CH_W-1:0] chan [NUM_CH];
    int unsigned     slot;
    out_t            res;
    chan[CH_RED]   = px.pix_red;
    chan[CH_GREEN] = px.pix_green;
    chan[CH_BLUE]  = px.pix_blue;
    if (pixel_pos == '0) begin
      group_full = px.full_reload;
      if (!group_full) begin
        for (int r = 0; r < WIN_SIDE; r++)
          for (int c = 0; c < WIN_SIDE - 1; c++)
            for (int ch = 0; ch < NUM_CH; ch++)
              win_ch[ch][r*WIN_SIDE+c] = win_ch[ch][r*WIN_SIDE+c+1];
      end
    end
    slot = group_full ? pixel_pos : pixel_pos * WIN_SIDE + (WIN_SIDE - 1);
    for (int ch = 0; ch < NUM_CH; ch++) win_ch[ch][slot] = chan[ch];
    pixel_pos = pixel_pos + 1'b1;
    if (pixel_pos == (group_full ? FULL_LEN : COL_LEN)) begin
      pixel_pos     = '0;
      res.out_red   = filter_channel(CH_RED);
      res.out_green = filter_channel(CH_GREEN);
      res.out_blue  = filter_channel(CH_BLUE);
      filtered_q    = {filtered_q, res};
    end
  endfunction

  function automatic in_t make_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                     logic [CH_W-1:0] b, logic f);
    in_t px;
    px.pix_red     = r;
    px.pix_green   = g;
    px.pix_blue    = b;
    px.full_reload = f;
    return px;
  endfunction

  function automatic logic [CH_W-1:0] random_level();
    logic [CH_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      default: v = CH_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_pixel(in_t px);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    absorb_pixel(px);
    pixels_sent++;
  endtask

  task automatic send_group(bit full);
    in_t px;
    int unsigned len;
    len = full ? WIN_CELLS : WIN_SIDE;
    for (int i = 0; i < len; i++) begin
      px = make_pixel(random_level(), random_level(), random_level(), 1'($urandom));
      if (i == 0) px.full_reload = full;
      send_pixel(px);
    end
    if (full) full_groups++;
    else col_groups++;
  endtask

  task automatic test_directed_groups();
    // column right after reset: kept columns are zeros, later flags ignored
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 1'b1));
    send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 1'b1));
    col_groups++;
    for (int i = 0; i < WIN_CELLS; i++)
      send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, (i == 0) ? 1'b1 : 1'b0));
    full_groups++;
    for (int i = 0; i < WIN_CELLS; i++)
      send_pixel(make_pixel(CH_W'(i * 31), CH_W'(255 - i * 31),
                            (i == CENTRE_CELL) ? 8'hFF : 8'h00,
                            (i == 0) ? 1'b1 : 1'(i)));
    full_groups++;
    for (int i = 0; i < WIN_SIDE; i++)
      send_pixel(make_pixel(8'h00, 8'h00, 8'h00, (i == 0) ? 1'b0 : 1'b1));
    col_groups++;
  endtask

  task automatic test_random_groups(int unsigned budget);
    int unsigned sent;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 3) == 0) begin
        send_group(1'b1);
        sent += WIN_CELLS;
      end else begin
        send_group(1'b0);
        sent += WIN_SIDE;
      end
    end
  endtask

  task automatic test_output_hold_off();
    gaps_on     = 1'b0;
    hold_cycles = HOLD_LEN;
    for (int i = 0; i < 15; i++) send_group(1'b0);
  endtask

  task automatic test_steady_stream(int unsigned budget);
    gaps_on = 1'b0;
    test_random_groups(budget);
  endtask

  task automatic check_channel(string name, logic [CH_W-1:0] exp_v,
                               logic [CH_W-1:0] act_v);
    if (act_v !== exp_v) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("mismatch on %s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
        out_ready_i <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filtered_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected window result: got %0d %0d %0d",
                   out_data_o.out_red, out_data_o.out_green, out_data_o.out_blue);
      end else begin
        want = filtered_q.pop_front();
        check_channel("red", want.out_red, out_data_o.out_red);
        check_channel("green", want.out_green, out_data_o.out_green);
        check_channel("blue", want.out_blue, out_data_o.out_blue);
        windows_checked++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for the filter");
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_groups();
    gaps_on = 1'b1;
    test_random_groups(420);
    test_output_hold_off();
    test_steady_stream(60);
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("pushed %0d pixels: %0d full reloads and %0d column slides",
             pixels_sent, full_groups, col_groups);
    $display("checked %0d filtered windows, with random stalls and a long output hold",
             windows_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
